[rtl/core/qsw_pkg.sv]
// Package for the query stop-word filter: beat types, table types, codes,
// default stop-word table and byte helpers. Depends on nothing.
`default_nettype none
package qsw_pkg;

  localparam int MAX_WORD_LEN  = 8;
  localparam int TABLE_ENTRIES = 64;
  localparam int NUM_DEFAULTS  = 44;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int LEN_W         = 4;
  localparam int POS_W         = $clog2(MAX_WORD_LEN);
  localparam int WORD_W        = 8 * MAX_WORD_LEN;

  localparam logic [1:0] MODE_QUERY = 2'd0;
  localparam logic [1:0] MODE_WRITE = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;

  localparam logic [23:0] WORD_AND = 24'h646E61;
  localparam logic [15:0] WORD_OR  = 16'h726F;
  localparam logic [23:0] WORD_NOT = 24'h746F6E;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  query_char;
    logic        end_of_query;
    logic [5:0]  entry_index;
    logic [63:0] stop_word;
    logic [3:0]  stop_word_length;
  } query_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       char_valid;
    logic       last;
    logic       entry_rejected;
  } result_t;

  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  idx;
    logic [WORD_W-1:0] word;
    logic [LEN_W-1:0]  len;
  } tbl_wr_t;

  typedef struct packed {
    logic              valid;
    logic [LEN_W-1:0]  len;
    logic [WORD_W-1:0] word;
  } tbl_entry_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SEARCH, ST_SPACE, ST_BUF, ST_CHAR, ST_EOQ, ST_FIN
  } state_t;

  function automatic logic [7:0] lower_byte(input logic [7:0] c);
    lower_byte = (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
  endfunction

  function automatic logic is_token_char(input logic [7:0] c);
    is_token_char = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h30 && c <= 8'h39) ||
                    c == CH_LPAR || c == CH_RPAR;
  endfunction

  // A string literal is right aligned with its first character on top;
  // the table keeps the first character in the low byte.
  function automatic tbl_entry_t mk_entry(input logic [63:0] s);
    tbl_entry_t e;
    int n;
    n = 0;
    for (int k = 0; k < 8; k++) begin
      if (s[8*k +: 8] != 8'd0) n = k + 1;
    end
    e.valid = 1'b1;
    e.len   = LEN_W'(n);
    e.word  = '0;
    for (int k = 0; k < 8; k++) begin
      if (k < n) e.word[8*k +: 8] = s[8*(n-1-k) +: 8];
    end
    mk_entry = e;
  endfunction

  function automatic tbl_entry_t def_entry(input logic [IDX_W-1:0] idx);
    tbl_entry_t e;
    e = '0;
    unique case (idx)
      6'd0:  e = mk_entry("a");
      6'd1:  e = mk_entry("an");
      6'd2:  e = mk_entry("are");
      6'd3:  e = mk_entry("as");
      6'd4:  e = mk_entry("at");
      6'd5:  e = mk_entry("be");
      6'd6:  e = mk_entry("by");
      6'd7:  e = mk_entry("for");
      6'd8:  e = mk_entry("from");
      6'd9:  e = mk_entry("has");
      6'd10: e = mk_entry("he");
      6'd11: e = mk_entry("in");
      6'd12: e = mk_entry("is");
      6'd13: e = mk_entry("it");
      6'd14: e = mk_entry("its");
      6'd15: e = mk_entry("of");
      6'd16: e = mk_entry("on");
      6'd17: e = mk_entry("that");
      6'd18: e = mk_entry("the");
      6'd19: e = mk_entry("to");
      6'd20: e = mk_entry("was");
      6'd21: e = mk_entry("will");
      6'd22: e = mk_entry("with");
      6'd23: e = mk_entry("what");
      6'd24: e = mk_entry("when");
      6'd25: e = mk_entry("where");
      6'd26: e = mk_entry("who");
      6'd27: e = mk_entry("how");
      6'd28: e = mk_entry("which");
      6'd29: e = mk_entry("this");
      6'd30: e = mk_entry("these");
      6'd31: e = mk_entry("those");
      6'd32: e = mk_entry("can");
      6'd33: e = mk_entry("could");
      6'd34: e = mk_entry("do");
      6'd35: e = mk_entry("does");
      6'd36: e = mk_entry("have");
      6'd37: e = mk_entry("had");
      6'd38: e = mk_entry("been");
      6'd39: e = mk_entry("being");
      6'd40: e = mk_entry("would");
      6'd41: e = mk_entry("should");
      6'd42: e = mk_entry("may");
      6'd43: e = mk_entry("might");
      default: e = '0;
    endcase
    def_entry = e;
  endfunction

endpackage
`default_nettype wire

[rtl/core/qsw_table.sv]
// Stop-word table: word and length memory with registered read, plus
// per-entry written and valid flags. Depends on qsw_pkg.
`default_nettype none
module qsw_table (
  input  logic                clk,
  input  logic                rst,
  input  qsw_pkg::tbl_wr_t    wr,
  input  logic                clr,
  input  logic [qsw_pkg::IDX_W-1:0] rd_addr,
  output qsw_pkg::tbl_entry_t rd_entry
);

  logic [qsw_pkg::WORD_W-1:0] mem_word [qsw_pkg::TABLE_ENTRIES];
  logic [qsw_pkg::LEN_W-1:0]  mem_len  [qsw_pkg::TABLE_ENTRIES];
  logic [qsw_pkg::TABLE_ENTRIES-1:0] written;
  logic [qsw_pkg::TABLE_ENTRIES-1:0] valid;

  logic [qsw_pkg::WORD_W-1:0] rd_word;
  logic [qsw_pkg::LEN_W-1:0]  rd_len;
  logic [qsw_pkg::IDX_W-1:0]  rd_idx;
  logic                       rd_written;
  logic                       rd_valid;
  qsw_pkg::tbl_entry_t        dflt;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem_word[wr.idx] <= wr.word;
      mem_len[wr.idx]  <= wr.len;
    end
    rd_word    <= mem_word[rd_addr];
    rd_len     <= mem_len[rd_addr];
    rd_idx     <= rd_addr;
    rd_written <= written[rd_addr];
    rd_valid   <= valid[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
      for (int i = 0; i < qsw_pkg::TABLE_ENTRIES; i++) begin
        valid[i] <= (i < qsw_pkg::NUM_DEFAULTS);
      end
    end else begin
      if (clr) valid <= '0;
      if (wr.en) begin
        written[wr.idx] <= 1'b1;
        valid[wr.idx]   <= (wr.len != '0);
      end
    end
  end

  // An entry never written since reset still holds its default word.
  always_comb begin
    dflt           = qsw_pkg::def_entry(rd_idx);
    rd_entry.valid = rd_valid;
    rd_entry.len   = rd_written ? rd_len : dflt.len;
    rd_entry.word  = rd_written ? rd_word : dflt.word;
  end

endmodule
`default_nettype wire

[rtl/core/query_stopword_filter.sv]
// Query stop-word filter. One beat on the query channel is a query byte, a
// table write or a table clear. Query bytes are lowercased; letters, digits
// and parentheses build tokens of up to eight bytes, anything else ends a
// token. A finished token is looked up in the 64-entry stop-word table by a
// sequencer that reads one entry per cycle from a single memory port and
// stops early on a hit. The query side stalls while an item is in work,
// so a new beat is taken only once the previous one is through. Kept
// tokens leave one byte per result beat with single spaces between them;
// the final beat of a query carries last, and a query with no output
// yields one empty beat with last. A table write yields one empty beat
// whose entry_rejected flag reports the words and, or and not. A token
// longer than eight bytes cannot match and is passed through as it
// arrives. Reset restores the 44 default stop words.
// Depends on qsw_pkg and qsw_table.
`default_nettype none
module query_stopword_filter (
  input  logic             clk,
  input  logic             rst,
  input  logic             query_valid,
  output logic             query_stall,
  input  qsw_pkg::query_t  query,
  output logic             result_valid,
  input  logic             result_stall,
  output qsw_pkg::result_t result
);

  qsw_pkg::state_t state, state_next;

  logic [7:0] ch, ch_next;
  logic       eoq, eoq_next;
  logic       phase, phase_next;
  logic       ovf, ovf_next;
  logic [qsw_pkg::LEN_W-1:0] token_len, token_len_next;
  logic       too_long, too_long_next;
  logic       emitted_any, emitted_any_next;
  logic [7:0] tok_buf [qsw_pkg::MAX_WORD_LEN];
  logic       buf_we;
  logic [qsw_pkg::POS_W-1:0] bi, bi_next;
  logic [qsw_pkg::IDX_W:0]   scnt, scnt_next;
  logic       cmp_v, cmp_v_next;

  qsw_pkg::result_t hold, hold_next;
  logic       hold_valid, hold_valid_next;
  logic       push;
  qsw_pkg::result_t push_beat;

  logic       accept, can_push, can_step, produce, hit;
  logic [7:0] new_ch, cin;
  logic [qsw_pkg::WORD_W-1:0] packed_tok, wword;
  logic [qsw_pkg::LEN_W-1:0]  wlen;
  logic       rej;
  qsw_pkg::tbl_wr_t    twr;
  logic                tclr;
  qsw_pkg::tbl_entry_t tent;

  qsw_table u_table (
    .clk(clk), .rst(rst), .wr(twr), .clr(tclr),
    .rd_addr(scnt[qsw_pkg::IDX_W-1:0]), .rd_entry(tent)
  );

  assign query_stall = (state != qsw_pkg::ST_IDLE);
  assign accept      = query_valid && !query_stall;
  assign can_push    = !result_valid || !result_stall;
  // A new byte displaces the held one, which then needs the output register.
  assign can_step    = !hold_valid || can_push;
  assign cin         = qsw_pkg::lower_byte(query.query_char);

  // Token packed like a table word, bytes past the length as zero.
  always_comb begin
    for (int k = 0; k < qsw_pkg::MAX_WORD_LEN; k++) begin
      packed_tok[8*k +: 8] = (k < int'(token_len)) ? tok_buf[k] : 8'd0;
    end
  end

  assign hit = cmp_v && tent.valid && tent.len == token_len && tent.word == packed_tok;

  // Table write word: lowercased, clipped to its length.
  always_comb begin
    wlen = (query.stop_word_length > 4'd8) ? 4'd8 : query.stop_word_length;
    for (int k = 0; k < 8; k++) begin
      wword[8*k +: 8] = (k < int'(wlen)) ?
                        qsw_pkg::lower_byte(query.stop_word[8*k +: 8]) : 8'd0;
    end
    rej = (wlen == 4'd3 && wword == {40'd0, qsw_pkg::WORD_AND}) ||
          (wlen == 4'd2 && wword == {48'd0, qsw_pkg::WORD_OR}) ||
          (wlen == 4'd3 && wword == {40'd0, qsw_pkg::WORD_NOT});
  end

  always_comb begin
    state_next       = state;
    ch_next          = ch;
    eoq_next         = eoq;
    phase_next       = phase;
    ovf_next         = ovf;
    token_len_next   = token_len;
    too_long_next    = too_long;
    emitted_any_next = emitted_any;
    bi_next          = bi;
    scnt_next        = scnt;
    cmp_v_next       = 1'b0;
    hold_next        = hold;
    hold_valid_next  = hold_valid;
    buf_we           = 1'b0;
    produce          = 1'b0;
    new_ch           = 8'd0;
    push             = 1'b0;
    push_beat        = hold;
    tclr             = 1'b0;
    twr.en           = 1'b0;
    twr.idx          = query.entry_index;
    twr.word         = wword;
    twr.len          = wlen;

    unique case (state)
      qsw_pkg::ST_IDLE: begin
        if (accept) begin
          ch_next    = cin;
          eoq_next   = (query.mode == qsw_pkg::MODE_QUERY) && query.end_of_query;
          phase_next = 1'b0;
          ovf_next   = 1'b0;
          case (query.mode)
            qsw_pkg::MODE_QUERY: begin
              if (qsw_pkg::is_token_char(cin)) begin
                if (too_long) begin
                  state_next = qsw_pkg::ST_CHAR;
                end else if (token_len < 4'(qsw_pkg::MAX_WORD_LEN)) begin
                  buf_we         = 1'b1;
                  token_len_next = token_len + 4'd1;
                  state_next     = qsw_pkg::ST_EOQ;
                end else begin
                  ovf_next   = 1'b1;
                  state_next = qsw_pkg::ST_SPACE;
                end
              end else if (!too_long && token_len != '0) begin
                scnt_next  = '0;
                state_next = qsw_pkg::ST_SEARCH;
              end else begin
                too_long_next  = 1'b0;
                token_len_next = '0;
                state_next     = qsw_pkg::ST_EOQ;
              end
            end
            qsw_pkg::MODE_WRITE: begin
              twr.en          = !rej;
              hold_next       = '{out_char: 8'd0, char_valid: 1'b0, last: 1'b0,
                                  entry_rejected: rej};
              hold_valid_next = 1'b1;
              state_next      = qsw_pkg::ST_FIN;
            end
            qsw_pkg::MODE_CLEAR: tclr = 1'b1;
            default: ;
          endcase
        end
      end

      qsw_pkg::ST_SEARCH: begin
        if (!scnt[qsw_pkg::IDX_W]) begin
          scnt_next  = scnt + 1'b1;
          cmp_v_next = 1'b1;
        end
        if (hit) begin
          token_len_next = '0;
          too_long_next  = 1'b0;
          state_next     = qsw_pkg::ST_EOQ;
        end else if (!cmp_v && scnt[qsw_pkg::IDX_W]) begin
          ovf_next   = 1'b0;
          state_next = qsw_pkg::ST_SPACE;
        end
      end

      qsw_pkg::ST_SPACE: begin
        bi_next = '0;
        if (!emitted_any) begin
          state_next = qsw_pkg::ST_BUF;
        end else if (can_step) begin
          produce    = 1'b1;
          new_ch     = qsw_pkg::CH_SPACE;
          state_next = qsw_pkg::ST_BUF;
        end
      end

      qsw_pkg::ST_BUF: begin
        if (can_step) begin
          produce = 1'b1;
          new_ch  = tok_buf[bi];
          bi_next = bi + 1'b1;
          if ({1'b0, bi} == token_len - 4'd1) begin
            emitted_any_next = 1'b1;
            if (ovf) begin
              state_next = qsw_pkg::ST_CHAR;
            end else begin
              token_len_next = '0;
              too_long_next  = 1'b0;
              state_next     = qsw_pkg::ST_EOQ;
            end
          end
        end
      end

      qsw_pkg::ST_CHAR: begin
        if (can_step) begin
          produce = 1'b1;
          new_ch  = ch;
          if (ovf) begin
            too_long_next  = 1'b1;
            token_len_next = '0;
            ovf_next       = 1'b0;
          end
          state_next = qsw_pkg::ST_EOQ;
        end
      end

      qsw_pkg::ST_EOQ: begin
        if (eoq && !phase) begin
          phase_next = 1'b1;
          if (!too_long && token_len != '0) begin
            scnt_next  = '0;
            state_next = qsw_pkg::ST_SEARCH;
          end else begin
            too_long_next  = 1'b0;
            token_len_next = '0;
          end
        end else begin
          state_next = qsw_pkg::ST_FIN;
        end
      end

      qsw_pkg::ST_FIN: begin
        if (!hold_valid && !eoq) begin
          state_next = qsw_pkg::ST_IDLE;
        end else if (can_push) begin
          push      = 1'b1;
          push_beat = hold_valid ? hold : '0;
          push_beat.last = eoq;
          hold_valid_next = 1'b0;
          if (eoq) emitted_any_next = 1'b0;
          state_next = qsw_pkg::ST_IDLE;
        end
      end

      default: state_next = qsw_pkg::ST_IDLE;
    endcase

    if (produce) begin
      push            = hold_valid;
      push_beat       = hold;
      hold_next       = '{out_char: new_ch, char_valid: 1'b1, last: 1'b0,
                          entry_rejected: 1'b0};
      hold_valid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= qsw_pkg::ST_IDLE;
      token_len    <= '0;
      too_long     <= 1'b0;
      emitted_any  <= 1'b0;
      hold_valid   <= 1'b0;
      result_valid <= 1'b0;
      cmp_v        <= 1'b0;
      eoq          <= 1'b0;
      phase        <= 1'b0;
      ovf          <= 1'b0;
    end else begin
      state        <= state_next;
      token_len    <= token_len_next;
      too_long     <= too_long_next;
      emitted_any  <= emitted_any_next;
      hold_valid   <= hold_valid_next;
      cmp_v        <= cmp_v_next;
      eoq          <= eoq_next;
      phase        <= phase_next;
      ovf          <= ovf_next;
      if (push) result_valid <= 1'b1;
      else if (!result_stall) result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    ch   <= ch_next;
    bi   <= bi_next;
    scnt <= scnt_next;
    hold <= hold_next;
    if (push) result <= push_beat;
    if (buf_we) tok_buf[token_len[qsw_pkg::POS_W-1:0]] <= cin;
  end

endmodule
`default_nettype wire

[rtl/core/qsw_checker.sv]
// Port-level checks for the query stop-word filter, bound to the top level.
// Depends on qsw_pkg.
`default_nettype none
module qsw_checker (
  input logic             clk,
  input logic             rst,
  input logic             query_valid,
  input logic             query_stall,
  input qsw_pkg::query_t  query,
  input logic             result_valid,
  input logic             result_stall,
  input qsw_pkg::result_t result
);

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("result beat changed while stalled");

  a_reject_empty: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.entry_rejected |-> !result.char_valid && !result.last)
    else $error("rejected table write beat carries a byte or last");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.char_valid |-> result.out_char == 8'd0)
    else $error("empty beat with nonzero byte");

  a_write_busy: assert property (@(posedge clk) disable iff (rst)
    query_valid && !query_stall && query.mode == qsw_pkg::MODE_WRITE |=> query_stall)
    else $error("table write did not hold off the next beat");

endmodule

bind query_stopword_filter qsw_checker u_qsw_checker (
  .clk(clk), .rst(rst), .query_valid(query_valid), .query_stall(query_stall),
  .query(query), .result_valid(result_valid), .result_stall(result_stall),
  .result(result)
);
`default_nettype wire
